@@ design/yuv420_to_rgb_crop_unit_defines.svh @@
// Assertion macros for the YUV 4:2:0 to RGB crop unit.
// Included by the files that check their own logic; SYNTH removes the checks.
`ifndef YUV420_TO_RGB_CROP_UNIT_DEFINES_SVH
`define YUV420_TO_RGB_CROP_UNIT_DEFINES_SVH

`ifndef SYNTH
`define Y2R_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define Y2R_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define Y2R_ASSERT(label, clk, rst_n, prop, msg)
`define Y2R_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

@@ design/y2r_pkg.sv @@
// Shared types and constants for the YUV 4:2:0 to RGB crop unit.
// No dependencies; used by the conversion datapath and the top level.
package y2r_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned RegIdxW = 3;

  localparam int unsigned FracBitsDef = 10;

  localparam int unsigned CoefYMilli = 1164;
  localparam int unsigned CoefRvMilli = 1596;
  localparam int unsigned CoefGvMilli = 813;
  localparam int unsigned CoefGuMilli = 391;
  localparam int unsigned CoefBuMilli = 2018;
  localparam int unsigned LumaOffset = 16;
  localparam int unsigned ChromaOffset = 128;
  localparam int unsigned ByteMax = 255;

  localparam logic [CoordW-1:0] FirstColRst = 12'd175;
  localparam logic [CoordW-1:0] LastColRst = 12'd988;
  localparam logic [CoordW-1:0] FirstRowRst = 12'd150;
  localparam logic [CoordW-1:0] LastRowRst = 12'd664;
  localparam logic ChanOrderRst = 1'b1;

  typedef enum logic [RegIdxW-1:0] {
    RegFirstCol = 3'd0,
    RegLastCol = 3'd1,
    RegFirstRow = 3'd2,
    RegLastRow = 3'd3,
    RegChanOrder = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OrderBgr = 1'b0,
    OrderRgb = 1'b1
  } chan_order_e;

  typedef struct packed {
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] chroma_blue;
    logic [SampleW-1:0] chroma_red;
    logic [CoordW-1:0] pixel_col;
    logic [CoordW-1:0] pixel_row;
  } pixel_req_t;

  typedef struct packed {
    logic [SampleW-1:0] chan_first;
    logic [SampleW-1:0] chan_middle;
    logic [SampleW-1:0] chan_last;
  } pixel_res_t;

endpackage

@@ design/y2r_convert.sv @@
// Fixed-point BT.601 video-range color conversion of one pixel, combinational.
// Depends on y2r_pkg for the payload types and coefficient constants.
module y2r_convert #(
  parameter int unsigned FRAC_BITS = y2r_pkg::FracBitsDef
) (
  input  logic [y2r_pkg::SampleW-1:0] luma_i,
  input  logic [y2r_pkg::SampleW-1:0] chroma_blue_i,
  input  logic [y2r_pkg::SampleW-1:0] chroma_red_i,
  input  y2r_pkg::chan_order_e        order_i,
  output y2r_pkg::pixel_res_t         res_o
);

  localparam int unsigned SumW = FRAC_BITS + 11;
  localparam int unsigned DiffW = y2r_pkg::SampleW + 2;
  localparam int unsigned One = 1 << FRAC_BITS;

  localparam logic signed [SumW-1:0] CoefY =
    SumW'((y2r_pkg::CoefYMilli * One + 500) / 1000);
  localparam logic signed [SumW-1:0] CoefRv =
    SumW'((y2r_pkg::CoefRvMilli * One + 500) / 1000);
  localparam logic signed [SumW-1:0] CoefGv =
    SumW'((y2r_pkg::CoefGvMilli * One + 500) / 1000);
  localparam logic signed [SumW-1:0] CoefGu =
    SumW'((y2r_pkg::CoefGuMilli * One + 500) / 1000);
  localparam logic signed [SumW-1:0] CoefBu =
    SumW'((y2r_pkg::CoefBuMilli * One + 500) / 1000);

  function automatic logic [y2r_pkg::SampleW-1:0] to_byte(logic signed [SumW-1:0] sum);
    logic [y2r_pkg::SampleW-1:0] val;
    if (sum[SumW-1] || (sum == '0)) begin
      val = '0;
    end else if (sum[SumW-2:FRAC_BITS+y2r_pkg::SampleW] != '0) begin
      val = y2r_pkg::SampleW'(y2r_pkg::ByteMax);
    end else begin
      val = sum[FRAC_BITS+y2r_pkg::SampleW-1:FRAC_BITS];
    end
    return val;
  endfunction

  logic signed [DiffW-1:0] y_s, u_s, v_s;
  logic signed [SumW-1:0] luma_term, rv_term, gv_term, gu_term, bu_term;
  logic signed [SumW-1:0] r_sum, g_sum, b_sum;
  logic [y2r_pkg::SampleW-1:0] r_byte, g_byte, b_byte;

  assign y_s = $signed({2'b00, luma_i}) - DiffW'(y2r_pkg::LumaOffset);
  assign u_s = $signed({2'b00, chroma_blue_i}) - DiffW'(y2r_pkg::ChromaOffset);
  assign v_s = $signed({2'b00, chroma_red_i}) - DiffW'(y2r_pkg::ChromaOffset);

  assign luma_term = CoefY * SumW'(y_s);
  assign rv_term = CoefRv * SumW'(v_s);
  assign gv_term = CoefGv * SumW'(v_s);
  assign gu_term = CoefGu * SumW'(u_s);
  assign bu_term = CoefBu * SumW'(u_s);

  assign r_sum = luma_term + rv_term;
  assign g_sum = luma_term - gv_term - gu_term;
  assign b_sum = luma_term + bu_term;

  assign r_byte = to_byte(r_sum);
  assign g_byte = to_byte(g_sum);
  assign b_byte = to_byte(b_sum);

  always_comb begin
    res_o.chan_middle = g_byte;
    case (order_i)
      y2r_pkg::OrderRgb: begin
        res_o.chan_first = r_byte;
        res_o.chan_last = b_byte;
      end
      default: begin
        res_o.chan_first = b_byte;
        res_o.chan_last = r_byte;
      end
    endcase
  end

endmodule

@@ design/yuv420_to_rgb_crop_unit.sv @@
// Cropped BT.601 YUV 4:2:0 to RGB pixel converter with an APB register port.
// A request is registered in the first stage; an in-window result and its strobe are registered in the second.
// Throughput: one pixel per cycle; busy stays low, and results cannot be stalled.
// Reset clears the valid bits of both pipeline stages and loads the default window and RGB order.
// Depends on y2r_pkg, y2r_convert and yuv420_to_rgb_crop_unit_defines.svh.
`include "yuv420_to_rgb_crop_unit_defines.svh"

module yuv420_to_rgb_crop_unit #(
  parameter int unsigned FRAC_BITS = y2r_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  y2r_pkg::pixel_req_t          req_i,
  output logic                         res_valid_o,
  output y2r_pkg::pixel_res_t          res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [y2r_pkg::AddrW-1:0]    paddr,
  input  logic [y2r_pkg::DataW-1:0]    pwdata,
  output logic [y2r_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  logic [y2r_pkg::CoordW-1:0] first_col_q, last_col_q, first_row_q, last_row_q;
  y2r_pkg::chan_order_e order_q;
  y2r_pkg::cfg_reg_e reg_idx;
  logic cfg_we, accept;

  y2r_pkg::pixel_req_t s1_req_q;
  logic s1_valid_q, s1_hit;
  y2r_pkg::pixel_res_t conv_res, res_q;
  logic res_valid_q;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign accept = start & ~busy;
  assign cfg_we = psel & penable & pwrite & pready;
  assign reg_idx = y2r_pkg::cfg_reg_e'(paddr[y2r_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_col_q <= y2r_pkg::FirstColRst;
      last_col_q <= y2r_pkg::LastColRst;
      first_row_q <= y2r_pkg::FirstRowRst;
      last_row_q <= y2r_pkg::LastRowRst;
      order_q <= y2r_pkg::chan_order_e'(y2r_pkg::ChanOrderRst);
    end else if (cfg_we) begin
      case (reg_idx)
        y2r_pkg::RegFirstCol: first_col_q <= pwdata[y2r_pkg::CoordW-1:0];
        y2r_pkg::RegLastCol: last_col_q <= pwdata[y2r_pkg::CoordW-1:0];
        y2r_pkg::RegFirstRow: first_row_q <= pwdata[y2r_pkg::CoordW-1:0];
        y2r_pkg::RegLastRow: last_row_q <= pwdata[y2r_pkg::CoordW-1:0];
        y2r_pkg::RegChanOrder: order_q <= y2r_pkg::chan_order_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      y2r_pkg::RegFirstCol: prdata = y2r_pkg::DataW'(first_col_q);
      y2r_pkg::RegLastCol: prdata = y2r_pkg::DataW'(last_col_q);
      y2r_pkg::RegFirstRow: prdata = y2r_pkg::DataW'(first_row_q);
      y2r_pkg::RegLastRow: prdata = y2r_pkg::DataW'(last_row_q);
      y2r_pkg::RegChanOrder: prdata = y2r_pkg::DataW'(order_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      res_valid_q <= s1_valid_q & s1_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_i;
    end
    if (s1_valid_q) begin
      res_q <= conv_res;
    end
  end

  assign s1_hit =
    (s1_req_q.pixel_col >= first_col_q) &&
    (s1_req_q.pixel_col <= last_col_q) &&
    (s1_req_q.pixel_row >= first_row_q) &&
    (s1_req_q.pixel_row <= last_row_q);

  y2r_convert #(
    .FRAC_BITS(FRAC_BITS)
  ) u_convert (
    .luma_i       (s1_req_q.luma),
    .chroma_blue_i(s1_req_q.chroma_blue),
    .chroma_red_i (s1_req_q.chroma_red),
    .order_i      (order_q),
    .res_o        (conv_res)
  );

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  `Y2R_ASSERT(a_stage_from_request, clk_i, rst_ni, s1_valid_q |-> $past(accept),
              "Pipeline stage valid without an accepted request.")
  `Y2R_ASSERT(a_result_from_stage, clk_i, rst_ni, res_valid_q |-> $past(s1_valid_q && s1_hit),
              "Result strobe without an in-window pixel in the stage before.")
  `Y2R_ASSERT(a_outside_dropped, clk_i, rst_ni, (s1_valid_q && !s1_hit) |=> !res_valid_q,
              "Pixel outside the crop window produced a result.")
  `Y2R_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy,
                    "Busy rose although the pipeline takes a request every cycle.")

endmodule
